### rtl/three_channel_programmable_timer_top_macros.svh
// ----------------------------------------------------------------------------
// Three-channel timer assertion macros
// Shared concurrent assertion forms, compiled out when ASSERT_OFF is set
// ----------------------------------------------------------------------------
`ifndef THREE_CHANNEL_PROGRAMMABLE_TIMER_TOP_MACROS_SVH
`define THREE_CHANNEL_PROGRAMMABLE_TIMER_TOP_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define TTPT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define TTPT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TTPT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define TTPT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

### rtl/ttpt_pkg.sv
// ----------------------------------------------------------------------------
// Three-channel timer package
// Types, register offsets and counter arithmetic helpers
// ----------------------------------------------------------------------------
`default_nettype none

package ttpt_pkg;

    localparam int NUM_CH = 3;
    localparam int CNT_W  = 21;
    localparam int RLD_W  = 20;
    localparam int SUM_W  = CNT_W + 2;
    localparam int PRE_W  = CNT_W + 3;

    // request kinds carried on tuser
    typedef enum logic [1:0] {
        REQ_TICK  = 2'd0,
        REQ_READ  = 2'd1,
        REQ_WRITE = 2'd2
    } req_t;

    // register offsets
    localparam logic [2:0] OFF_CTRL13 = 3'd0;
    localparam logic [2:0] OFF_CTRL2  = 3'd1;

    // configuration register indexes
    localparam logic CFG_ENABLE   = 1'b0;
    localparam logic CFG_IRQ_MASK = 1'b1;

    // per-tick decrements
    localparam logic signed [SUM_W-1:0] FAST_STEP = SUM_W'(104);
    localparam logic signed [SUM_W-1:0] SLOW_STEP = SUM_W'(1);

    // counter and preset limits
    localparam logic signed [SUM_W-1:0] CNT_MAX = SUM_W'(1048575);
    localparam logic signed [SUM_W-1:0] CNT_MIN = -SUM_W'(1048576);
    localparam logic signed [PRE_W-1:0] RLD_MAX = PRE_W'(524287);
    localparam logic signed [PRE_W-1:0] RLD_MIN = -PRE_W'(524288);

    typedef struct packed {
        logic [7:0] wdata;
        logic [2:0] offset;
        req_t       req;
    } item_t;

    typedef struct packed {
        logic       irq;
        logic       handled;
        logic [7:0] rdata;
    } result_t;

    // saturate a widened sum to the counter range
    function automatic logic signed [CNT_W-1:0] clamp_cnt(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] w;
        w = v;
        if (v > CNT_MAX)
        begin
            w = CNT_MAX;
        end
        else if (v < CNT_MIN)
        begin
            w = CNT_MIN;
        end
        return w[CNT_W-1:0];
    endfunction

    // optional scale by eight, saturated to the preset range
    function automatic logic signed [RLD_W-1:0] scale_preset(
        input logic signed [CNT_W-1:0] v,
        input logic                    div8
    );
        logic signed [PRE_W-1:0] w;
        w = div8 ? {v, 3'b000} : {{3{v[CNT_W-1]}}, v};
        if (w > RLD_MAX)
        begin
            w = RLD_MAX;
        end
        else if (w < RLD_MIN)
        begin
            w = RLD_MIN;
        end
        return w[RLD_W-1:0];
    endfunction

endpackage

`default_nettype wire

### rtl/three_channel_programmable_timer_top.sv
// ----------------------------------------------------------------------------
// Three-channel programmable timer
// Path: a request is registered in the input register, then processed by
//   the core into the output register once the output slot is free.
// Throughput: one request per cycle unless a result waits undrained in the
//   output register; all three counters and the register file are updated
//   together in one pass.
// Reset: rst_n clears all counters, presets and flags, holds the counters
//   in preset and enables the block; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module three_channel_programmable_timer_top
    import ttpt_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // reg_offset[2:0], write_data[10:3], zero pad
    input  wire logic [1:0]  s_tuser,   // req_type[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // read_data[7:0], handled[8], irq_request[9], zero pad
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic        cfg_data
);

    logic    item_valid;
    item_t   item;
    logic    out_busy;
    logic    fire;
    result_t res;

    // core takes a request when the output slot is free
    assign fire = item_valid && !out_busy;

    ttpt_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .take       (fire),
        .item_valid (item_valid),
        .item       (item)
    );

    ttpt_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .item      (item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .res       (res)
    );

    ttpt_out_reg u_out_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (fire),
        .res      (res),
        .busy     (out_busy),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

### rtl/ttpt_in_reg.sv
// ----------------------------------------------------------------------------
// Three-channel timer input register
// Holds one request for the core; refills in the cycle it is consumed
// ----------------------------------------------------------------------------
`default_nettype none

module ttpt_in_reg
    import ttpt_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // reg_offset[2:0], write_data[10:3], zero pad
    input  wire logic [1:0]  s_tuser,   // req_type[1:0]
    input  wire logic        take,
    output logic             item_valid,
    output item_t            item
);

    logic  valid_reg;
    item_t item_reg;

    // free when empty or being consumed this cycle
    assign s_tready   = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            valid_reg <= s_tvalid;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg.req    <= req_t'(s_tuser);
            item_reg.offset <= s_tdata[2:0];
            item_reg.wdata  <= s_tdata[10:3];
        end
    end

endmodule

`default_nettype wire

### rtl/ttpt_core.sv
// ----------------------------------------------------------------------------
// Three-channel timer core
// Timer state, register decode and single-pass update for one request
// ----------------------------------------------------------------------------
`default_nettype none

`include "three_channel_programmable_timer_top_macros.svh"

module ttpt_core
    import ttpt_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    fire,
    input  wire item_t   item,
    input  wire logic    cfg_valid,
    output logic         cfg_ready,
    input  wire logic    cfg_index,
    input  wire logic    cfg_data,
    output result_t      res
);

    // state
    logic signed [CNT_W-1:0] cnt_reg [2*NUM_CH];
    logic signed [CNT_W-1:0] cnt_next [2*NUM_CH];
    logic signed [RLD_W-1:0] rld_reg [2*NUM_CH];
    logic signed [RLD_W-1:0] rld_next [2*NUM_CH];
    logic [2:0]        mode_reg [NUM_CH];
    logic [2:0]        mode_next [NUM_CH];
    logic [NUM_CH-1:0] run_reg, run_next;
    logic [NUM_CH-1:0] half_reg, half_next;
    logic [NUM_CH-1:0] fast_reg, fast_next;
    logic [NUM_CH-1:0] flag_reg, flag_next;
    logic [NUM_CH-1:0] mask_reg, mask_next;
    logic [NUM_CH-1:0] wide_reg, wide_next;
    logic              held_reg, held_next;
    logic              csel_reg, csel_next;
    logic              div8_reg, div8_next;
    logic [7:0]        rlatch_reg, rlatch_next;
    logic [7:0]        wlatch_reg, wlatch_next;
    logic              irq_reg, irq_next;
    logic              dev_en_reg;
    logic              gmask_reg;

    // per-channel tick arithmetic
    logic signed [CNT_W-1:0] tick_dec [NUM_CH];
    logic signed [RLD_W-1:0] tick_src [NUM_CH];
    logic signed [CNT_W-1:0] tick_rel [NUM_CH];
    logic [NUM_CH-1:0]       tick_zero;

    // decode strobes
    logic              act;
    logic              clear;
    logic [NUM_CH-1:0] ctl_hit;
    logic [NUM_CH-1:0] cnt_hit;
    logic [NUM_CH-1:0] load;

    assign act       = fire && dev_en_reg;
    assign cfg_ready = 1'b1;

    // decrement, then reload from the active half
    always_comb
    begin
        for (int i = 0; i < NUM_CH; i++)
        begin
            tick_dec[i]  = clamp_cnt({{2{cnt_reg[i][CNT_W-1]}}, cnt_reg[i]}
                                     - (fast_reg[i] ? FAST_STEP : SLOW_STEP));
            tick_src[i]  = (wide_reg[i] || !half_reg[i]) ? rld_reg[i] : rld_reg[i+NUM_CH];
            tick_rel[i]  = clamp_cnt({{2{tick_dec[i][CNT_W-1]}}, tick_dec[i]}
                                     + {{(SUM_W-RLD_W){tick_src[i][RLD_W-1]}}, tick_src[i]});
            tick_zero[i] = tick_dec[i][CNT_W-1] || (tick_dec[i] == '0);
        end
    end

    // request decode and next state
    always_comb
    begin
        cnt_next    = cnt_reg;
        rld_next    = rld_reg;
        mode_next   = mode_reg;
        run_next    = run_reg;
        half_next   = half_reg;
        fast_next   = fast_reg;
        flag_next   = flag_reg;
        mask_next   = mask_reg;
        wide_next   = wide_reg;
        held_next   = held_reg;
        csel_next   = csel_reg;
        div8_next   = div8_reg;
        rlatch_next = rlatch_reg;
        wlatch_next = wlatch_reg;
        irq_next    = irq_reg;
        clear       = 1'b0;
        ctl_hit     = '0;
        cnt_hit     = '0;
        load        = '0;
        res.rdata   = 8'h00;
        res.handled = 1'b0;

        if (act)
        begin
            case (item.req)
                REQ_TICK:
                begin
                    if (!held_reg)
                    begin
                        for (int i = 0; i < NUM_CH; i++)
                        begin
                            if (run_reg[i])
                            begin
                                cnt_next[i] = tick_dec[i];
                                if (tick_zero[i])
                                begin
                                    flag_next[i] = 1'b1;
                                    if (!mask_reg[i] && !gmask_reg)
                                    begin
                                        irq_next = 1'b1;
                                    end
                                    if (mode_reg[i][2])
                                    begin
                                        run_next[i] = 1'b0;
                                    end
                                    else
                                    begin
                                        cnt_next[i]  = tick_rel[i];
                                        half_next[i] = !half_reg[i];
                                    end
                                end
                            end
                        end
                    end
                end
                REQ_READ:
                begin
                    if (item.offset == OFF_CTRL2)
                    begin
                        // status read clears what it returns
                        res.rdata   = {irq_reg, 4'b0000, flag_reg};
                        flag_next   = '0;
                        irq_next    = 1'b0;
                        res.handled = 1'b1;
                    end
                    else if (item.offset != OFF_CTRL13)
                    begin
                        res.handled = 1'b1;
                        for (int i = 0; i < NUM_CH; i++)
                        begin
                            if (item.offset[2:1] == 2'(i + 1))
                            begin
                                if (item.offset[0])
                                begin
                                    res.rdata = rlatch_reg;
                                end
                                else if (wide_reg[i])
                                begin
                                    res.rdata   = cnt_reg[i][15:8];
                                    rlatch_next = cnt_reg[i][7:0];
                                end
                                else
                                begin
                                    res.rdata   = cnt_reg[i][7:0];
                                    rlatch_next = cnt_reg[i+NUM_CH][7:0];
                                end
                            end
                        end
                    end
                end
                REQ_WRITE:
                begin
                    res.handled = 1'b1;
                    case (item.offset)
                        OFF_CTRL13:
                        begin
                            if (csel_reg)
                            begin
                                if (item.wdata[0])
                                begin
                                    clear = 1'b1;
                                end
                                else
                                begin
                                    ctl_hit[0] = 1'b1;
                                    held_next  = 1'b0;
                                end
                            end
                            else
                            begin
                                div8_next  = item.wdata[0];
                                ctl_hit[2] = 1'b1;
                            end
                        end
                        OFF_CTRL2:
                        begin
                            ctl_hit[1] = 1'b1;
                            csel_next  = item.wdata[0];
                        end
                        default:
                        begin
                            if (!item.offset[0])
                            begin
                                wlatch_next = item.wdata;
                            end
                            else
                            begin
                                for (int i = 0; i < NUM_CH; i++)
                                begin
                                    cnt_hit[i] = (item.offset[2:1] == 2'(i + 1));
                                end
                            end
                        end
                    endcase

                    // reset of all counters, held in preset
                    if (clear)
                    begin
                        for (int i = 0; i < 2*NUM_CH; i++)
                        begin
                            cnt_next[i] = '0;
                            rld_next[i] = '0;
                        end
                        for (int i = 0; i < NUM_CH; i++)
                        begin
                            mode_next[i] = 3'b000;
                        end
                        run_next  = '0;
                        half_next = '0;
                        fast_next = '0;
                        held_next = 1'b1;
                    end

                    for (int i = 0; i < NUM_CH; i++)
                    begin
                        // control register write
                        if (ctl_hit[i])
                        begin
                            mask_next[i] = !item.wdata[6];
                            fast_next[i] = item.wdata[1];
                            wide_next[i] = !item.wdata[2];
                            mode_next[i] = item.wdata[5:3];
                            if (item.wdata[3])
                            begin
                                run_next[i]  = 1'b0;
                                flag_next[i] = 1'b0;
                            end
                            else if (item.wdata[4])
                            begin
                                load[i] = 1'b1;
                            end
                        end
                        // counter low byte write
                        if (cnt_hit[i])
                        begin
                            if (wide_reg[i])
                            begin
                                cnt_next[i] = {5'b00000, wlatch_reg, item.wdata};
                            end
                            else
                            begin
                                cnt_next[i]        = {13'b0, wlatch_reg};
                                cnt_next[i+NUM_CH] = {13'b0, item.wdata};
                            end
                            if (!mode_reg[i][1])
                            begin
                                load[i] = 1'b1;
                            end
                        end
                        // preset load and start
                        if (load[i])
                        begin
                            rld_next[i] = scale_preset(cnt_next[i], div8_next);
                            if (!wide_next[i])
                            begin
                                rld_next[i+NUM_CH] = scale_preset(cnt_next[i+NUM_CH], div8_next);
                            end
                            run_next[i]  = 1'b1;
                            half_next[i] = 1'b0;
                            flag_next[i] = 1'b0;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        res.irq = irq_next;
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 2*NUM_CH; i++)
            begin
                cnt_reg[i] <= '0;
                rld_reg[i] <= '0;
            end
            for (int i = 0; i < NUM_CH; i++)
            begin
                mode_reg[i] <= 3'b000;
            end
            run_reg    <= '0;
            half_reg   <= '0;
            fast_reg   <= '0;
            flag_reg   <= '0;
            mask_reg   <= '1;
            wide_reg   <= '1;
            held_reg   <= 1'b1;
            csel_reg   <= 1'b0;
            div8_reg   <= 1'b0;
            rlatch_reg <= 8'h00;
            wlatch_reg <= 8'h00;
            irq_reg    <= 1'b0;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            rld_reg    <= rld_next;
            mode_reg   <= mode_next;
            run_reg    <= run_next;
            half_reg   <= half_next;
            fast_reg   <= fast_next;
            flag_reg   <= flag_next;
            mask_reg   <= mask_next;
            wide_reg   <= wide_next;
            held_reg   <= held_next;
            csel_reg   <= csel_next;
            div8_reg   <= div8_next;
            rlatch_reg <= rlatch_next;
            wlatch_reg <= wlatch_next;
            irq_reg    <= irq_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_en_reg <= 1'b1;
            gmask_reg  <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_ENABLE:   dev_en_reg <= cfg_data;
                CFG_IRQ_MASK: gmask_reg  <= cfg_data;
                default:      ;
            endcase
        end
    end

    // checks
    `TTPT_ASSERT_NXT(a_status_clears_irq, clk, rst_n,
        act && item.req == REQ_READ && item.offset == OFF_CTRL2,
        !irq_reg && flag_reg == '0, "status read did not clear interrupt and flags")
    `TTPT_ASSERT_NXT(a_clear_holds, clk, rst_n,
        act && item.req == REQ_WRITE && item.offset == OFF_CTRL13 && csel_reg && item.wdata[0],
        held_reg && run_reg == '0, "counter reset left a channel running")
    `TTPT_ASSERT_NXT(a_disabled_quiet, clk, rst_n,
        fire && !dev_en_reg,
        $stable(irq_reg) && $stable(flag_reg) && $stable(run_reg),
        "disabled block changed state")
    `TTPT_ASSERT_IMP(a_tick_unhandled, clk, rst_n,
        fire && item.req == REQ_TICK,
        !res.handled && res.rdata == 8'h00, "tick produced read data")

endmodule

`default_nettype wire

### rtl/ttpt_out_reg.sv
// ----------------------------------------------------------------------------
// Three-channel timer output register
// Holds one result until the downstream side takes it
// ----------------------------------------------------------------------------
`default_nettype none

module ttpt_out_reg
    import ttpt_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        load,
    input  wire result_t     res,
    output logic             busy,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata    // read_data[7:0], handled[8], irq_request[9], zero pad
);

    logic    valid_reg;
    result_t res_reg;

    // slot is taken while a result waits and is not drained this cycle
    assign busy     = valid_reg && !m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = {6'b000000, res_reg};

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

endmodule

`default_nettype wire
